@@ rtl/core/oqe_pkg.sv @@
// Shared types and codes for the ordered queue with erase.
package oqe_pkg;

  typedef enum logic [1:0] {
    FN_PUSH  = 2'd0,
    FN_POP   = 2'd1,
    FN_ERASE = 2'd2,
    FN_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_EMPTY    = 2'd2,
    STAT_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic tok;
    logic shf;
  } link_t;

endpackage

@@ rtl/core/oqe_cell.sv @@
// One queue slot: holds a key, searches or shifts as the token passes through.
module oqe_cell import oqe_pkg::*; #(
  parameter int KEY_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [KEY_WIDTH-1:0] wr_key,
  input  logic [KEY_WIDTH-1:0] cmp_key,
  input  link_t                lnk_in,
  input  logic [KEY_WIDTH-1:0] bk_in,
  input  logic [KEY_WIDTH-1:0] nxt_key,
  input  logic                 nxt_used,
  output link_t                lnk_out,
  output logic [KEY_WIDTH-1:0] bk_out,
  output logic [KEY_WIDTH-1:0] key_o,
  output logic                 used_o
);

  logic [KEY_WIDTH-1:0] key_r;
  logic                 used_r;
  logic                 tok_r;
  logic                 shf_r;
  logic [KEY_WIDTH-1:0] bk_r;
  logic                 hit;

  assign hit = tok_r && (shf_r || (used_r && (key_r == cmp_key)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      tok_r  <= 1'b0;
    end else begin
      tok_r <= lnk_in.tok;
      if (wr_en) begin
        used_r <= 1'b1;
      end else if (hit) begin
        used_r <= nxt_used;
      end
    end
  end

  always_ff @(posedge clk) begin
    shf_r <= lnk_in.shf;
    bk_r  <= bk_in;
    if (wr_en) begin
      key_r <= wr_key;
    end else if (hit) begin
      key_r <= nxt_key;
    end
  end

  always_comb begin
    lnk_out.tok = tok_r;
    lnk_out.shf = hit;
    if (hit) begin
      bk_out = nxt_used ? nxt_key : bk_r;
    end else begin
      bk_out = used_r ? key_r : bk_r;
    end
  end

  assign key_o  = key_r;
  assign used_o = used_r;

endmodule

@@ rtl/core/ordered_queue_with_erase.sv @@
// Ordered key queue with erase, built as a row of DEPTH slot cells.
// Sequence: push, the unused selector and pop on an empty queue go from idle to the
// finish state; pop and erase first sweep a token down the row, one cell per cycle.
// Throughput: one item at a time; a new item is taken only back in idle, after the
// result enters the output registers, which wait until the last result is taken.
// Reset (synchronous, rst_n low) empties the queue and returns the control to idle.
module ordered_queue_with_erase import oqe_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32,
  localparam int CNT_W    = $clog2(DEPTH + 1),
  localparam int POS_W    = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_func,
  input  logic [KEY_WIDTH-1:0] in_key,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [KEY_WIDTH-1:0] out_front_key,
  output logic [KEY_WIDTH-1:0] out_back_key,
  output logic [CNT_W-1:0]     out_occupancy
);

  state_t               state_r, state_nxt;
  logic [POS_W-1:0]     pos_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [KEY_WIDTH-1:0] back_r;
  logic [KEY_WIDTH-1:0] srch_key_r;
  status_t              stat_r;
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  logic [KEY_WIDTH-1:0] out_front_r;
  logic [KEY_WIDTH-1:0] out_back_r;
  logic [CNT_W-1:0]     out_occ_r;

  logic                 accept;
  logic                 full;
  logic                 empty;
  logic                 push_go;
  logic                 sweep_go;
  logic                 sweep_end;
  logic                 out_load;
  link_t                inject;

  link_t                lnk   [DEPTH];
  logic [KEY_WIDTH-1:0] bk_w  [DEPTH];
  logic [KEY_WIDTH-1:0] key_w [DEPTH];
  logic                 used_w[DEPTH];

  assign full  = (cnt_r == CNT_W'(DEPTH));
  assign empty = (cnt_r == '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sweep_go ? ST_SWEEP : ST_FINISH;
        end
      end
      ST_SWEEP: begin
        if (pos_r == POS_W'(DEPTH - 1)) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    sweep_end  = 1'b0;
    out_load   = 1'b0;
    case (state_r)
      ST_IDLE:   in_ready  = 1'b1;
      ST_SWEEP:  sweep_end = (pos_r == POS_W'(DEPTH - 1));
      ST_FINISH: out_load  = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  assign accept     = in_valid && in_ready;
  assign push_go    = accept && (in_func == FN_PUSH) && !full;
  assign sweep_go   = ((in_func == FN_POP) && !empty) || (in_func == FN_ERASE);
  assign inject.tok = accept && sweep_go;
  assign inject.shf = (in_func == FN_POP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (push_go) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (sweep_end && lnk[DEPTH-1].shf) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pos_r      <= '0;
      srch_key_r <= in_key;
      if ((in_func == FN_PUSH) && full) begin
        stat_r <= STAT_FULL;
      end else if ((in_func == FN_POP) && empty) begin
        stat_r <= STAT_EMPTY;
      end else begin
        stat_r <= STAT_OK;
      end
    end else if (state_r == ST_SWEEP) begin
      pos_r <= pos_r + POS_W'(1);
      if (sweep_end && !lnk[DEPTH-1].shf) begin
        stat_r <= STAT_NOTFOUND;
      end
    end
    if (push_go) begin
      back_r <= in_key;
    end else if (sweep_end && lnk[DEPTH-1].shf) begin
      back_r <= bk_w[DEPTH-1];
    end
    if (out_load) begin
      out_status_r <= stat_r;
      out_front_r  <= used_w[0] ? key_w[0] : '0;
      out_back_r   <= empty ? '0 : back_r;
      out_occ_r    <= cnt_r;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    link_t                c_lnk_in;
    logic [KEY_WIDTH-1:0] c_bk_in;
    logic [KEY_WIDTH-1:0] c_nxt_key;
    logic                 c_nxt_used;

    if (i == 0) begin : g_first
      assign c_lnk_in = inject;
      assign c_bk_in  = '0;
    end else begin : g_mid
      assign c_lnk_in = lnk[i-1];
      assign c_bk_in  = bk_w[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign c_nxt_key  = '0;
      assign c_nxt_used = 1'b0;
    end else begin : g_inner
      assign c_nxt_key  = key_w[i+1];
      assign c_nxt_used = used_w[i+1];
    end

    oqe_cell #(
      .KEY_WIDTH(KEY_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wr_en   (push_go && (cnt_r == CNT_W'(i))),
      .wr_key  (in_key),
      .cmp_key (srch_key_r),
      .lnk_in  (c_lnk_in),
      .bk_in   (c_bk_in),
      .nxt_key (c_nxt_key),
      .nxt_used(c_nxt_used),
      .lnk_out (lnk[i]),
      .bk_out  (bk_w[i]),
      .key_o   (key_w[i]),
      .used_o  (used_w[i])
    );
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_front_key = out_front_r;
  assign out_back_key  = out_back_r;
  assign out_occupancy = out_occ_r;

endmodule

@@ rtl/core/oqe_checker.sv @@
// Port-level checks for the ordered queue with erase, bound to the top level.
module oqe_checker import oqe_pkg::*; #(
  parameter int DEPTH     = 64,
  parameter int KEY_WIDTH = 32,
  localparam int CNT_W    = $clog2(DEPTH + 1)
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [1:0]           out_status,
  input logic [KEY_WIDTH-1:0] out_front_key,
  input logic [KEY_WIDTH-1:0] out_back_key,
  input logic [CNT_W-1:0]     out_occupancy
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status) &&
      $stable(out_front_key) && $stable(out_back_key) && $stable(out_occupancy)))
    else $error("result item changed while waiting");

  a_empty_keys: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_occupancy == '0)) |-> ((out_front_key == '0) && (out_back_key == '0)))
    else $error("empty queue reports a key");

  a_full_stat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_FULL)) |-> (out_occupancy == CNT_W'(DEPTH)))
    else $error("full status below depth");

  a_empty_stat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STAT_EMPTY)) |-> (out_occupancy == '0))
    else $error("empty status on a non-empty queue");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("item taken while one is in progress");

endmodule

bind ordered_queue_with_erase oqe_checker #(
  .DEPTH    (DEPTH),
  .KEY_WIDTH(KEY_WIDTH)
) u_oqe_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_status   (out_status),
  .out_front_key(out_front_key),
  .out_back_key (out_back_key),
  .out_occupancy(out_occupancy)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the ordered key queue with push, pop and erase.
module testbench;
  import oqe_pkg::*;

  localparam int DEPTH         = 64;
  localparam int KEY_WIDTH     = 32;
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int RANDOM_ITEMS  = 1350;
  localparam int MAX_OPS       = RANDOM_ITEMS + 64;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int LONG_HOLD     = 400;
  localparam int HOLD_TRIGGER  = 500;
  localparam int SETTLE_CYCLES = 2 * DEPTH + 16;
  localparam int POOL_SIZE     = 12;

  typedef struct {
    func_t                func;
    logic [KEY_WIDTH-1:0] key;
    bit                   wait_idle;
  } op_request_t;

  typedef struct {
    status_t              status;
    logic [KEY_WIDTH-1:0] front_key;
    logic [KEY_WIDTH-1:0] back_key;
    logic [CNT_W-1:0]     occupancy;
  } queue_snapshot_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_func = FN_NOP;
  logic [KEY_WIDTH-1:0] in_key = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           out_status;
  logic [KEY_WIDTH-1:0] out_front_key;
  logic [KEY_WIDTH-1:0] out_back_key;
  logic [CNT_W-1:0]     out_occupancy;

  op_request_t          op_requests[MAX_OPS];
  queue_snapshot_t      queue_snapshots[MAX_OPS];
  logic [KEY_WIDTH-1:0] held_keys[DEPTH];
  logic [KEY_WIDTH-1:0] key_pool[POOL_SIZE];

  int op_wr          = 0;
  int op_rd          = 0;
  int snap_wr        = 0;
  int snap_rd        = 0;
  int held_count     = 0;
  int error_count    = 0;
  int cycle_count    = 0;
  int items_offered  = 0;
  int items_taken    = 0;
  int burst_left     = 1;
  int gap_left       = 0;
  int hold_left      = 0;
  bit long_hold_done = 1'b0;
  int ready_mode     = 0;
  int mode_left      = 0;

  ordered_queue_with_erase #(
    .DEPTH(DEPTH),
    .KEY_WIDTH(KEY_WIDTH)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_func(in_func),
    .in_key(in_key),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_front_key(out_front_key),
    .out_back_key(out_back_key),
    .out_occupancy(out_occupancy)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic queue_snapshot_t apply_queue_op(func_t func, logic [KEY_WIDTH-1:0] key);
    queue_snapshot_t snap;
    int              hit;
    snap.status = STAT_OK;
    hit = -1;
    case (func)
      FN_PUSH: begin
        if (held_count >= DEPTH) begin
          snap.status = STAT_FULL;
        end else begin
          held_keys[held_count] = key;
          held_count++;
        end
      end
      FN_POP: begin
        if (held_count == 0) snap.status = STAT_EMPTY;
        else hit = 0;
      end
      FN_ERASE: begin
        for (int i = 0; i < held_count && hit < 0; i++)
          if (held_keys[i] == key) hit = i;
        if (hit < 0) snap.status = STAT_NOTFOUND;
      end
      default: ;
    endcase
    if (hit >= 0) begin
      for (int i = hit; i < held_count - 1; i++) held_keys[i] = held_keys[i + 1];
      held_count--;
    end
    snap.front_key = (held_count == 0) ? '0 : held_keys[0];
    snap.back_key  = (held_count == 0) ? '0 : held_keys[held_count - 1];
    snap.occupancy = CNT_W'(held_count);
    return snap;
  endfunction

  function automatic logic [KEY_WIDTH-1:0] pick_key();
    if ($urandom_range(0, 99) < 70) return key_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom();
  endfunction

  task automatic add_op(func_t func, logic [KEY_WIDTH-1:0] key, bit wait_idle);
    op_request_t req;
    req.func      = func;
    req.key       = key;
    req.wait_idle = wait_idle;
    op_requests[op_wr] = req;
    op_wr++;
  endtask

  task automatic report_mismatch(string what, logic [KEY_WIDTH-1:0] got,
                                 logic [KEY_WIDTH-1:0] want);
    $display("mismatch on %s at cycle %0d: got %h, want %h", what, cycle_count, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  always @(negedge clk) begin : driver
    op_request_t req;
    if (rst_n) begin
      if (in_valid && items_taken != items_offered) begin
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (op_rd == op_wr) begin
        in_valid <= 1'b0;
      end else if (op_requests[op_rd].wait_idle && snap_rd != snap_wr) begin
        in_valid <= 1'b0;
      end else begin
        req = op_requests[op_rd];
        op_rd++;
        in_valid <= 1'b1;
        in_func  <= req.func;
        in_key   <= req.key;
        items_offered++;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 4))
            0, 1:    gap_left = 0;
            2, 3:    gap_left = $urandom_range(1, 4);
            default: gap_left = $urandom_range(5, 40);
          endcase
        end
      end
    end
  end

  always @(negedge clk) begin : receiver
    if (rst_n) begin
      if (!long_hold_done && items_taken >= HOLD_TRIGGER) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left  = $urandom_range(10, 80);
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (ready_mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= ($urandom_range(0, 1) == 1);
          2:       out_ready <= ($urandom_range(0, 4) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : monitor
    queue_snapshot_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (snap_rd == snap_wr) begin
          report_mismatch("item with nothing outstanding", KEY_WIDTH'(out_occupancy), '0);
        end else begin
          want = queue_snapshots[snap_rd];
          snap_rd++;
          if (out_status !== want.status)
            report_mismatch("status", KEY_WIDTH'(out_status), KEY_WIDTH'(want.status));
          if (out_front_key !== want.front_key)
            report_mismatch("front_key", out_front_key, want.front_key);
          if (out_back_key !== want.back_key)
            report_mismatch("back_key", out_back_key, want.back_key);
          if (out_occupancy !== want.occupancy)
            report_mismatch("occupancy", KEY_WIDTH'(out_occupancy), KEY_WIDTH'(want.occupancy));
        end
      end
      if (in_valid && in_ready) begin
        items_taken++;
        queue_snapshots[snap_wr] = apply_queue_op(func_t'(in_func), in_key);
        snap_wr++;
      end
    end
  end

  initial begin
    int    generated;
    int    phase;
    int    phase_len;
    int    roll;
    int    push_cut;
    int    pop_cut;
    int    erase_cut;
    func_t func;
    bit    wait_idle;

    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom();

    add_op(FN_POP, 32'h0000_0000, 1'b0);
    add_op(FN_ERASE, 32'h0000_0005, 1'b0);
    add_op(FN_NOP, 32'hFFFF_FFFF, 1'b0);
    add_op(FN_PUSH, 32'h0000_0000, 1'b0);
    add_op(FN_PUSH, 32'hFFFF_FFFF, 1'b0);
    add_op(FN_PUSH, 32'hAAAA_AAAA, 1'b0);
    add_op(FN_PUSH, 32'h0000_0000, 1'b0);
    add_op(FN_PUSH, 32'h5555_5555, 1'b0);
    add_op(FN_ERASE, 32'h0000_0000, 1'b0);
    add_op(FN_ERASE, 32'h5555_5555, 1'b0);
    add_op(FN_ERASE, 32'hAAAA_AAAA, 1'b0);
    add_op(FN_ERASE, 32'h1234_5678, 1'b0);
    add_op(FN_NOP, 32'h0000_0000, 1'b0);
    add_op(FN_POP, 32'hFFFF_FFFF, 1'b0);
    add_op(FN_PUSH, 32'h0000_0010, 1'b0);
    add_op(FN_PUSH, 32'h0000_0020, 1'b0);
    add_op(FN_PUSH, 32'h0000_0030, 1'b0);
    add_op(FN_ERASE, 32'h0000_0020, 1'b0);
    add_op(FN_POP, 32'h0000_0000, 1'b0);
    add_op(FN_ERASE, 32'h0000_0030, 1'b0);
    add_op(FN_ERASE, 32'h0000_0030, 1'b0);
    add_op(FN_PUSH, 32'h8000_0001, 1'b0);
    add_op(FN_POP, 32'h0000_0000, 1'b0);
    add_op(FN_POP, 32'h0000_0000, 1'b0);

    generated = 0;
    phase = 0;
    while (generated < RANDOM_ITEMS) begin
      phase_len = $urandom_range(30, 110);
      case (phase % 3)
        0: begin push_cut = 75; pop_cut = 85; erase_cut = 97; end
        1: begin push_cut = 45; pop_cut = 70; erase_cut = 97; end
        default: begin push_cut = 20; pop_cut = 60; erase_cut = 97; end
      endcase
      for (int i = 0; i < phase_len && generated < RANDOM_ITEMS; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < push_cut) func = FN_PUSH;
        else if (roll < pop_cut) func = FN_POP;
        else if (roll < erase_cut) func = FN_ERASE;
        else func = FN_NOP;
        wait_idle = (i == 0) && (phase == 1 || $urandom_range(0, 3) == 0);
        add_op(func, (func == FN_POP || func == FN_NOP) ? $urandom() : pick_key(), wait_idle);
        generated++;
      end
      phase++;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (op_rd != op_wr || items_taken != items_offered || snap_rd != snap_wr)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/oqe_pkg.sv
rtl/core/oqe_cell.sv
rtl/core/ordered_queue_with_erase.sv
rtl/core/oqe_checker.sv
tb/sv/testbench.sv
